/* rtl/cfec_pkg.sv */
`timescale 1ns / 1ps
package cfec_pkg;

	// datapath width of the CORDIC x, y and angle values
	localparam int CW = 34;
	localparam int CORDIC_STAGES_DEF = 18;
	localparam int IDX_W = 1;

	// configuration register indexes
	localparam logic [IDX_W-1:0] REG_FACE = 1'd0;
	localparam logic [IDX_W-1:0] REG_EDGE = 1'd1;

	localparam logic [14:0] EDGE_RESET = 15'd1024;
	localparam logic [17:0] COORD_MAX = 18'd131072;
	localparam logic signed [18:0] ONE_Q16 = 19'sd65536;
	localparam logic signed [31:0] GAIN_Q30 = 32'sd1768195363;
	localparam logic signed [CW-1:0] ANG_PI = 34'sh0_8000_0000;
	localparam logic signed [CW-1:0] ANG_HALF_PI = 34'sh0_4000_0000;

	// arctangent of 2^-i, pi = 2^31
	localparam logic [31:0] ATAN_TAB [32] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
		32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
		32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
		32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
		32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
		32'h00000001, 32'h00000000
	};

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [CW-1:0] ang;
		logic signed [CW-1:0] aux;   // value carried alongside the rotation
		logic                 zero;  // both inputs were zero
	} cord_t;

endpackage

/* rtl/cfec_cell.sv */
`timescale 1ns / 1ps
module cfec_cell #(
	parameter int STAGE = 0
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                adv,
	input  logic                vld_in,
	input  cfec_pkg::cord_t     d_in,
	output logic                vld_out,
	output cfec_pkg::cord_t     d_out
);

	logic signed [cfec_pkg::CW-1:0] dx;
	logic signed [cfec_pkg::CW-1:0] dy;
	logic signed [cfec_pkg::CW-1:0] da;
	cfec_pkg::cord_t nxt;
	logic vld_q;
	cfec_pkg::cord_t d_q;

	// one micro-rotation toward y = 0
	always_comb begin
		dx = d_in.y >>> STAGE;
		dy = d_in.x >>> STAGE;
		da = {{(cfec_pkg::CW-32){1'b0}}, cfec_pkg::ATAN_TAB[STAGE]};
		nxt = d_in;
		if (!d_in.y[cfec_pkg::CW-1]) begin
			nxt.x = d_in.x + dx;
			nxt.y = d_in.y - dy;
			nxt.ang = d_in.ang + da;
		end else begin
			nxt.x = d_in.x - dx;
			nxt.y = d_in.y + dy;
			nxt.ang = d_in.ang - da;
		end
	end

	// advance valid with the pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (adv) begin
			vld_q <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			d_q <= nxt;
		end
	end

	assign vld_out = vld_q;
	assign d_out = d_q;

endmodule

/* rtl/cfec_chain.sv */
`timescale 1ns / 1ps
module cfec_chain #(
	parameter int CORDIC_STAGES = cfec_pkg::CORDIC_STAGES_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            adv,
	input  logic            vld_in,
	input  cfec_pkg::cord_t d_in,
	output logic            vld_out,
	output cfec_pkg::cord_t d_out
);

	logic            vld_l [CORDIC_STAGES+1];
	cfec_pkg::cord_t d_l   [CORDIC_STAGES+1];

	assign vld_l[0] = vld_in;
	assign d_l[0] = d_in;

	// row of rotation cells, one shift amount each
	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
		cfec_cell #(.STAGE(i)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.adv    (adv),
			.vld_in (vld_l[i]),
			.d_in   (d_l[i]),
			.vld_out(vld_l[i+1]),
			.d_out  (d_l[i+1])
		);
	end

	assign vld_out = vld_l[CORDIC_STAGES];
	assign d_out = d_l[CORDIC_STAGES];

endmodule

/* rtl/cube_face_to_equirect_coords.sv */
`timescale 1ns / 1ps
// Cube-face pixel position to equirectangular source position.
// Slave channel s_*: one transaction carries coord_a and coord_b (unsigned Q2.16).
// Master channel m_*: one transaction per input carries src_u and src_v (unsigned Q.8).
// cfg_*: write face_select (index 0) and source_edge (index 1) while the block is idle.
// Datapath: face mapping and gain multiply, a row of CORDIC_STAGES rotation cells for
// atan2(y,x), a second row for atan2(z,r), then the edge scaling multiply.
// One transaction is accepted every cycle unless the pipeline stalls, set by the fully
// pipelined rows of rotation cells.
// Reset clears all valid bits and sets face_select to 0 and source_edge to 1024.
// When the receiver stalls, the whole pipeline holds; s_tready drops only while a
// result waits in the output register and m_tready is low.
module cube_face_to_equirect_coords #(
	parameter int CORDIC_STAGES = cfec_pkg::CORDIC_STAGES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [39:0]                   s_tdata,   // coord_a[17:0], coord_b[35:18], zero fill
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [55:0]                   m_tdata,   // src_u[24:0], src_v[48:25], zero fill
	input  logic                          cfg_wr_en,
	input  logic [cfec_pkg::IDX_W-1:0]    cfg_addr,
	input  logic [14:0]                   cfg_wdata
);

	localparam int CW = cfec_pkg::CW;

	logic [2:0]  face_q;
	logic [14:0] edge_q;
	logic        adv;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			face_q <= 3'd0;
			edge_q <= cfec_pkg::EDGE_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_addr)
				cfec_pkg::REG_FACE: face_q <= cfg_wdata[2:0];
				cfec_pkg::REG_EDGE: edge_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// pre-rotation into the right half plane, zero vector detect
	function automatic cfec_pkg::cord_t pre_rot(logic signed [CW-1:0] x,
		logic signed [CW-1:0] y, logic signed [CW-1:0] aux);
		cfec_pkg::cord_t c;
		c.x = x;
		c.y = y;
		c.ang = '0;
		c.aux = aux;
		c.zero = (x == '0) && (y == '0);
		if (x[CW-1]) begin
			if (!y[CW-1]) begin
				c.x = y;
				c.y = -x;
				c.ang = cfec_pkg::ANG_HALF_PI;
			end else begin
				c.x = -y;
				c.y = x;
				c.ang = -cfec_pkg::ANG_HALF_PI;
			end
		end
		return c;
	endfunction

	// stage 1: saturate and map onto the cube face
	logic [17:0] a_sat, b_sat;
	logic signed [18:0] a_s, b_s, fx, fy, fz;
	logic signed [18:0] x_s1, y_s1, z_s1;
	logic vld_s1;

	always_comb begin
		a_sat = (s_tdata[17:0] > cfec_pkg::COORD_MAX) ? cfec_pkg::COORD_MAX : s_tdata[17:0];
		b_sat = (s_tdata[35:18] > cfec_pkg::COORD_MAX) ? cfec_pkg::COORD_MAX : s_tdata[35:18];
		a_s = signed'({1'b0, a_sat});
		b_s = signed'({1'b0, b_sat});
		unique case (face_q)
			3'd1: begin
				fx = a_s - cfec_pkg::ONE_Q16; fy = -cfec_pkg::ONE_Q16;
				fz = cfec_pkg::ONE_Q16 - b_s;
			end
			3'd2: begin
				fx = cfec_pkg::ONE_Q16; fy = a_s - cfec_pkg::ONE_Q16;
				fz = cfec_pkg::ONE_Q16 - b_s;
			end
			3'd3: begin
				fx = cfec_pkg::ONE_Q16 - a_s; fy = cfec_pkg::ONE_Q16;
				fz = cfec_pkg::ONE_Q16 - b_s;
			end
			3'd4: begin
				fx = cfec_pkg::ONE_Q16 - b_s; fy = a_s - cfec_pkg::ONE_Q16;
				fz = cfec_pkg::ONE_Q16;
			end
			3'd5: begin
				fx = cfec_pkg::ONE_Q16 - b_s; fy = a_s - cfec_pkg::ONE_Q16;
				fz = -cfec_pkg::ONE_Q16;
			end
			default: begin
				fx = -cfec_pkg::ONE_Q16; fy = cfec_pkg::ONE_Q16 - a_s;
				fz = cfec_pkg::ONE_Q16 - b_s;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s1 <= fx;
			y_s1 <= fy;
			z_s1 <= fz;
		end
	end

	// stage 2: scale z by the CORDIC gain, widen x and y to Q28
	logic signed [50:0] zk_prod;
	logic signed [CW-1:0] zk, x28, y28;
	cfec_pkg::cord_t p1_s2;
	logic vld_s2;

	always_comb begin
		zk_prod = 51'(z_s1) * 51'(cfec_pkg::GAIN_Q30);
		zk = CW'(zk_prod >>> 18);
		x28 = CW'(x_s1) <<< 12;
		y28 = CW'(y_s1) <<< 12;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			p1_s2 <= pre_rot(x28, y28, zk);
		end
	end

	// first row: theta and r
	cfec_pkg::cord_t p1_out;
	logic vld_p1;

	cfec_chain #(.CORDIC_STAGES(CORDIC_STAGES)) u_chain_theta (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.vld_in (vld_s2),
		.d_in   (p1_s2),
		.vld_out(vld_p1),
		.d_out  (p1_out)
	);

	// stage between rows: clamp theta, start atan2(zk, r)
	logic signed [CW-1:0] theta, r;
	cfec_pkg::cord_t p2_s3;
	logic vld_s3;

	always_comb begin
		theta = p1_out.zero ? '0 : p1_out.ang;
		r = p1_out.zero ? '0 : p1_out.x;
		if (theta > cfec_pkg::ANG_PI) theta = cfec_pkg::ANG_PI;
		if (theta < -cfec_pkg::ANG_PI) theta = -cfec_pkg::ANG_PI;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s3 <= vld_p1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			p2_s3 <= pre_rot(r, p1_out.aux, theta);
		end
	end

	// second row: phi
	cfec_pkg::cord_t p2_out;
	logic vld_p2;

	cfec_chain #(.CORDIC_STAGES(CORDIC_STAGES)) u_chain_phi (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.vld_in (vld_s3),
		.d_in   (p2_s3),
		.vld_out(vld_p2),
		.d_out  (p2_out)
	);

	// scale by the source edge
	logic signed [CW-1:0] phi, u_ang, v_ang;
	logic [47:0] u_prod_s4, v_prod_s4;
	logic vld_s4;

	always_comb begin
		phi = p2_out.zero ? '0 : p2_out.ang;
		if (phi > cfec_pkg::ANG_HALF_PI) phi = cfec_pkg::ANG_HALF_PI;
		if (phi < -cfec_pkg::ANG_HALF_PI) phi = -cfec_pkg::ANG_HALF_PI;
		u_ang = p2_out.aux + cfec_pkg::ANG_PI;
		v_ang = cfec_pkg::ANG_HALF_PI - phi;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (adv) begin
			vld_s4 <= vld_p2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			u_prod_s4 <= 48'(u_ang[32:0]) * 48'(edge_q);
			v_prod_s4 <= 48'(v_ang[32:0]) * 48'(edge_q);
		end
	end

	// output register
	logic        out_vld_q;
	logic [24:0] src_u_q;
	logic [23:0] src_v_q;

	assign adv = !out_vld_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			src_u_q <= u_prod_s4[46:22];
			src_v_q <= v_prod_s4[45:22];
		end
	end

	assign s_tready = adv;
	assign m_tvalid = out_vld_q;
	assign m_tdata = {7'd0, src_v_q, src_u_q};

	a_u_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ({1'b0, src_u_q} <= {1'b0, edge_q, 10'd0}))
		else $error("src_u above 4*edge");
	a_v_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (src_v_q <= {edge_q, 9'd0}))
		else $error("src_v above 2*edge");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready == (!m_tvalid || m_tready))
		else $error("input ready does not follow the output register");

endmodule

/* bench/cube_face_to_equirect_coords_test.sv */
`timescale 1ns / 1ps
module cube_face_to_equirect_coords_test;
	import cfec_pkg::*;

	localparam int STAGES = CORDIC_STAGES_DEF;
	localparam int LATENCY = 2 * STAGES + 5;
	localparam int WATCHDOG_LIMIT = 20000;

	typedef struct packed {
		logic [24:0] src_u;
		logic [23:0] src_v;
	} coords_t;

	// expected source positions, oldest first
	class coords_scoreboard;
		coords_t pending[$];
		int errors;
		logic [2:0] face;
		logic [14:0] edge_len;

		function new();
			errors = 0;
			face = 3'd0;
			edge_len = EDGE_RESET;
		endfunction

		// CORDIC vectoring: angle with pi = 2^31, magnitude carries gain K
		function automatic longint vector_angle(longint x, longint y, output longint mag);
			longint ang;
			longint t;
			longint dx;
			longint dy;
			ang = 0;
			if (x == 0 && y == 0) begin
				mag = 0;
				return 0;
			end
			if (x < 0) begin
				t = x;
				if (y >= 0) begin
					x = y; y = -t; ang = ANG_HALF_PI;
				end else begin
					x = -y; y = t; ang = -ANG_HALF_PI;
				end
			end
			for (int i = 0; i < ((STAGES > 32) ? 32 : STAGES); i++) begin
				dx = y >>> i;
				dy = x >>> i;
				if (y >= 0) begin
					x += dx; y -= dy; ang += longint'(ATAN_TAB[i]);
				end else begin
					x -= dx; y += dy; ang -= longint'(ATAN_TAB[i]);
				end
			end
			mag = x;
			return ang;
		endfunction

		function automatic coords_t map_pixel(logic [17:0] ca, logic [17:0] cb);
			longint a, b, x, y, z, r, rm, theta, phi, zk, one, pi, hpi;
			longint unsigned uu, vv;
			coords_t res;
			one = 65536;
			pi = 64'sd2147483648;
			hpi = 64'sd1073741824;
			a = (ca > COORD_MAX) ? COORD_MAX : ca;
			b = (cb > COORD_MAX) ? COORD_MAX : cb;
			case (face)
				3'd1: begin x = a - one; y = -one; z = one - b; end
				3'd2: begin x = one; y = a - one; z = one - b; end
				3'd3: begin x = one - a; y = one; z = one - b; end
				3'd4: begin x = one - b; y = a - one; z = one; end
				3'd5: begin x = one - b; y = a - one; z = -one; end
				default: begin x = -one; y = one - a; z = one - b; end
			endcase
			x = x * 4096; y = y * 4096; z = z * 4096;
			theta = vector_angle(x, y, r);
			zk = (z * 64'sd1768195363) >>> 30;
			phi = vector_angle(r, zk, rm);
			if (theta > pi) theta = pi;
			if (theta < -pi) theta = -pi;
			if (phi > hpi) phi = hpi;
			if (phi < -hpi) phi = -hpi;
			uu = (longint'(theta + pi) * longint'(edge_len)) >> 22;
			vv = (longint'(hpi - phi) * longint'(edge_len)) >> 22;
			res.src_u = uu[24:0];
			res.src_v = vv[23:0];
			return res;
		endfunction

		function void note_input(logic [17:0] ca, logic [17:0] cb);
			pending.push_back(map_pixel(ca, cb));
		endfunction

		function void check_result(logic [55:0] data);
			coords_t want;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result u=%0d v=%0d", $time, data[24:0], data[48:25]);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (data[24:0] !== want.src_u) begin
				$display("%0t: src_u expected %0d actual %0d", $time, want.src_u, data[24:0]);
				errors++;
			end
			if (data[48:25] !== want.src_v) begin
				$display("%0t: src_v expected %0d actual %0d", $time, want.src_v, data[48:25]);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [39:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [55:0] m_tdata;
	logic cfg_wr_en = 1'b0;
	logic [IDX_W-1:0] cfg_addr = '0;
	logic [14:0] cfg_wdata = '0;

	coords_scoreboard board = new();
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	bit hold_off = 1'b0;
	int quiet_cycles = 0;

	cube_face_to_equirect_coords dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// track accepted transactions on both sides
	always @(posedge clk) begin
		if (s_tvalid && s_tready)
			board.note_input(s_tdata[17:0], s_tdata[35:18]);
		if (m_tvalid && m_tready)
			board.check_result(m_tdata);
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	// receiver: random stalls, or a long hold-off when asked
	always @(posedge clk) begin
		if (!arst_n)
			m_tready <= 1'b0;
		else
			m_tready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
	end

	// watchdog
	always @(posedge clk) begin
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("cube_face_to_equirect_coords test failed");
			$finish;
		end
	end

	task automatic write_reg(logic [IDX_W-1:0] idx, logic [14:0] val);
		cfg_wr_en <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		if (idx == REG_FACE)
			board.face = val[2:0];
		else
			board.edge_len = val;
	endtask

	task automatic send_pixel(logic [17:0] ca, logic [17:0] cb);
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {4'd0, cb, ca};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	// random coordinate biased toward the corners and the face center, with some out-of-range values
	function automatic logic [17:0] pick_coord();
		case ($urandom_range(9))
			0: return 18'd0;
			1: return COORD_MAX;
			2: return 18'd65536;
			3: return 18'($urandom_range(262143, 131073));
			default: return 18'($urandom_range(131072));
		endcase
	endfunction

	initial begin
		logic [14:0] edges [4];
		edges = '{15'd1, 15'd16384, 15'd32767, 15'd0};
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: every face select at the extremes and center, out-of-range coordinates on faces 0 and 1
		for (int f = 0; f < 8; f++) begin
			write_reg(REG_FACE, f[14:0]);
			send_pixel(18'd0, 18'd0);
			send_pixel(COORD_MAX, COORD_MAX);
			send_pixel(18'd65536, 18'd65536);
			if (f < 2)
				send_pixel(18'h3FFFF, 18'h3FFFF);
			drain();
		end

		// long receiver hold-off while the sender keeps offering
		write_reg(REG_FACE, 15'd2);
		hold_off = 1'b1;
		fork
			begin
				repeat (LATENCY * 3) @(posedge clk);
				hold_off = 1'b0;
			end
			for (int i = 0; i < LATENCY + 20; i++)
				send_pixel(pick_coord(), pick_coord());
		join
		drain();

		// random phases across edge settings and idle patterns
		for (int ph = 0; ph < 9; ph++) begin
			send_idle_pct = (ph < 3) ? 30 : (ph < 6) ? 60 : 0;
			recv_idle_pct = (ph < 3) ? 60 : (ph < 6) ? 30 : 0;
			write_reg(REG_EDGE, (ph < 4) ? edges[ph] : 15'($urandom_range(16384, 1)));
			for (int blk = 0; blk < 4; blk++) begin
				write_reg(REG_FACE, 15'($urandom_range(7)));
				for (int i = 0; i < 16; i++)
					send_pixel(pick_coord(), pick_coord());
				drain();
			end
		end
		send_idle_pct = 0;
		recv_idle_pct = 0;
		drain();

		if (board.errors == 0 && board.pending.size() == 0)
			$display("cube_face_to_equirect_coords test passed");
		else
			$display("cube_face_to_equirect_coords test failed");
		$finish;
	end
endmodule
